@@ rtl/core/fra_pkg.sv @@
`timescale 1ns / 1ps

package fra_pkg;

  // fixed field widths of the frame and message items
  localparam int BUS_W  = 2;
  localparam int ID_W   = 7;
  localparam int BYTE_W = 8;

  // buses served; a header on a higher bus number drops its frame
  localparam int BUSES = 4;

  // header byte layout: bit 7 marks the last frame, bits 6..0 the message id
  localparam int HDR_LAST_BIT = 7;

  typedef struct packed {
    logic [BUS_W-1:0]  bus;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [BUS_W-1:0]  out_bus;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] out_byte;
    logic              message_last;
    logic              truncated;
  } out_item_t;

endpackage

@@ rtl/core/fra_stream_if.sv @@
`timescale 1ns / 1ps

interface fra_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/fra_slot_tbl.sv @@
`timescale 1ns / 1ps

module fra_slot_tbl #(
  parameter int SLOTS  = 8,
  parameter int SLOT_W = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     lookup_en,
  input  logic [fra_pkg::BUS_W-1:0] lookup_bus,
  input  logic [fra_pkg::ID_W-1:0]  lookup_id,
  output logic                     found,
  output logic                     is_new,
  output logic [SLOT_W-1:0]        slot,
  input  logic                     free_en,
  input  logic [SLOT_W-1:0]        free_slot
);

  logic [SLOTS-1:0]                used_r;
  logic [fra_pkg::BUS_W-1:0]       bus_r [SLOTS];
  logic [fra_pkg::ID_W-1:0]        tag_r [SLOTS];

  logic [SLOTS-1:0]                hit;
  logic [SLOTS-1:0]                free;
  logic [SLOT_W-1:0]               hit_idx;
  logic [SLOT_W-1:0]               free_idx;
  logic                            alloc;

  // compare every slot in parallel, then take the lowest match or free slot
  always_comb begin
    hit      = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = used_r[i] && (bus_r[i] == lookup_bus) && (tag_r[i] == lookup_id);
    end
    free = ~used_r;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign is_new = ~(|hit);
  assign found  = (|hit) | (|free);
  assign slot   = (|hit) ? hit_idx : free_idx;
  assign alloc  = lookup_en && is_new && (|free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (alloc) begin
        used_r[free_idx] <= 1'b1;
      end
      if (free_en) begin
        used_r[free_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      bus_r[free_idx] <= lookup_bus;
      tag_r[free_idx] <= lookup_id;
    end
  end

endmodule

@@ rtl/core/frame_reassembler_top.sv @@
`timescale 1ns / 1ps
// Timing: a header or payload byte is taken when accepted; once a last frame ends, the first
//   message byte passes the drain state register, the read data register and the output register.
// Throughput: one frame byte per cycle while the input is open; after a last frame the input
//   stalls until the message is read out; the store streams one byte per cycle unless the output stalls.
// Reset (synchronous, rst_n low): slot pool empty, expecting a header, no drain;
//   message store and slot length memory are not cleared.

module frame_reassembler_top #(
  parameter int SLOTS       = 8,
  parameter int MSG_BYTES   = 64,
  parameter int FRAME_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  fra_stream_if.sink          in_if,
  fra_stream_if.source        out_if
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W  = $clog2(MSG_BYTES + 1);
  localparam int FC_W   = $clog2(FRAME_BYTES);
  localparam int DEPTH  = SLOTS * MSG_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int META_W = LEN_W + 1;

  // top-level modes
  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // ---------------------------------------------------------------------------
  // Memories: message bytes per slot, and {overflow, length} per slot
  // ---------------------------------------------------------------------------
  logic [fra_pkg::BYTE_W-1:0] store_mem [DEPTH];
  logic [META_W-1:0]          meta_mem  [SLOTS];

  // ---------------------------------------------------------------------------
  // Frame tracking state
  // ---------------------------------------------------------------------------
  logic                       st_r, st_nxt;
  logic                       exp_hdr_r, exp_hdr_nxt;
  logic                       hdr_last_r, hdr_last_nxt;
  logic [fra_pkg::ID_W-1:0]   hdr_id_r, hdr_id_nxt;
  logic [fra_pkg::BUS_W-1:0]  frm_bus_r, frm_bus_nxt;
  logic                       bound_r, bound_nxt;
  logic [SLOT_W-1:0]          cur_slot_r, cur_slot_nxt;
  logic [ADDR_W-1:0]          cur_base_r, cur_base_nxt;
  logic [FC_W-1:0]            fc_r, fc_nxt;
  logic                       first_r, first_nxt;
  logic                       new_r, new_nxt;
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [META_W-1:0]          meta_q_r;

  // drain state
  logic [LEN_W-1:0]           drn_len_r, drn_len_nxt;
  logic                       drn_ovf_r, drn_ovf_nxt;
  logic [LEN_W-1:0]           drn_k_r, drn_k_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_last_r;
  logic [fra_pkg::BYTE_W-1:0] mem_q_r;

  // output register
  logic                       out_v_r, out_v_nxt;
  fra_pkg::out_item_t         out_d_r;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  fra_pkg::in_item_t          req;
  logic                       in_acc;
  logic                       hdr_acc;
  logic                       pay_acc;
  logic                       bus_ok;
  logic                       lookup_en;

  // slot table lookup
  logic                       lk_found;
  logic                       lk_new;
  logic [SLOT_W-1:0]          lk_slot;
  logic                       free_en;

  // payload datapath
  logic [LEN_W-1:0]           len_cur;
  logic                       ovf_cur;
  logic                       st_we;
  logic [ADDR_W-1:0]          st_waddr;
  logic                       meta_we;
  logic                       drain_go;

  // drain control
  logic                       out_free;
  logic                       issue;
  logic                       load_out;
  logic [ADDR_W-1:0]          rd_addr;

  assign req       = in_if.payload;
  assign in_if.ready = (st_r == ST_RUN);
  assign in_acc    = in_if.valid && in_if.ready;
  assign hdr_acc   = in_acc && exp_hdr_r;
  assign pay_acc   = in_acc && !exp_hdr_r;
  assign bus_ok    = int'(req.bus) < fra_pkg::BUSES;
  // a header-only frame never reaches the slot table
  assign lookup_en = hdr_acc && !req.frame_end && bus_ok;

  fra_slot_tbl #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_slot_tbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_en  (lookup_en),
    .lookup_bus (req.bus),
    .lookup_id  (req.data_byte[fra_pkg::ID_W-1:0]),
    .found      (lk_found),
    .is_new     (lk_new),
    .slot       (lk_slot),
    .free_en    (free_en),
    .free_slot  (cur_slot_r)
  );

  // Working length and overflow: on the first payload byte of a frame take
  // them from the metadata read issued by the header (or zero for a fresh
  // slot); later bytes use the running copy.
  always_comb begin
    if (first_r) begin
      len_cur = new_r ? '0 : meta_q_r[LEN_W-1:0];
      ovf_cur = new_r ? 1'b0 : meta_q_r[LEN_W];
    end else begin
      len_cur = len_r;
      ovf_cur = ovf_r;
    end
  end

  assign st_waddr = cur_base_r + ADDR_W'(len_cur);

  // ---------------------------------------------------------------------------
  // Frame control
  // ---------------------------------------------------------------------------
  always_comb begin
    st_nxt       = st_r;
    exp_hdr_nxt  = exp_hdr_r;
    hdr_last_nxt = hdr_last_r;
    hdr_id_nxt   = hdr_id_r;
    frm_bus_nxt  = frm_bus_r;
    bound_nxt    = bound_r;
    cur_slot_nxt = cur_slot_r;
    cur_base_nxt = cur_base_r;
    fc_nxt       = fc_r;
    first_nxt    = first_r;
    new_nxt      = new_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    drn_len_nxt  = drn_len_r;
    drn_ovf_nxt  = drn_ovf_r;
    st_we        = 1'b0;
    meta_we      = 1'b0;
    drain_go     = 1'b0;

    if (hdr_acc) begin
      // latch the header; bind a slot unless the frame is header-only
      hdr_last_nxt = req.data_byte[fra_pkg::HDR_LAST_BIT];
      hdr_id_nxt   = req.data_byte[fra_pkg::ID_W-1:0];
      fc_nxt       = '0;
      bound_nxt    = 1'b0;
      if (!req.frame_end) begin
        exp_hdr_nxt = 1'b0;
        frm_bus_nxt = req.bus;
        if (bus_ok && lk_found) begin
          bound_nxt    = 1'b1;
          cur_slot_nxt = lk_slot;
          cur_base_nxt = ADDR_W'(lk_slot) * ADDR_W'(MSG_BYTES);
          new_nxt      = lk_new;
          first_nxt    = 1'b1;
        end
      end
    end

    if (pay_acc) begin
      len_nxt   = len_cur;
      ovf_nxt   = ovf_cur;
      first_nxt = 1'b0;
      if (bound_r) begin
        meta_we = 1'b1;
        if (fc_r >= FC_W'(FRAME_BYTES - 1)) begin
          // frame too long: drop the byte, flag the message
          ovf_nxt = 1'b1;
        end else begin
          fc_nxt = fc_r + FC_W'(1);
          if (len_cur < LEN_W'(MSG_BYTES)) begin
            st_we   = 1'b1;
            len_nxt = len_cur + LEN_W'(1);
          end else begin
            // message store full: drop the byte, flag the message
            ovf_nxt = 1'b1;
          end
        end
      end
      if (req.frame_end) begin
        exp_hdr_nxt = 1'b1;
        bound_nxt   = 1'b0;
        if (bound_r && hdr_last_r) begin
          // last frame done: hand the message to the drain and free the slot
          drain_go    = 1'b1;
          drn_len_nxt = len_nxt;
          drn_ovf_nxt = ovf_nxt;
          st_nxt      = ST_DRAIN;
        end
      end
    end

    // every read has moved into the output register: reopen the input
    if (st_r == ST_DRAIN && drn_k_r == drn_len_r && !pend_r) begin
      st_nxt = ST_RUN;
    end
  end

  assign free_en = drain_go;

  // ---------------------------------------------------------------------------
  // Drain: read one byte a cycle, hold the read data while the output stalls
  // ---------------------------------------------------------------------------
  assign out_free = !out_v_r || out_if.ready;
  assign issue    = (st_r == ST_DRAIN) && (drn_k_r < drn_len_r) && (!pend_r || out_free);
  assign load_out = pend_r && out_free;
  assign rd_addr  = cur_base_r + ADDR_W'(drn_k_r);

  always_comb begin
    drn_k_nxt = drain_go ? '0 : drn_k_r;
    if (issue) begin
      drn_k_nxt = drn_k_r + LEN_W'(1);
    end
    pend_nxt  = issue || (pend_r && !out_free);
    out_v_nxt = load_out || (out_v_r && !out_if.ready);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_RUN;
      exp_hdr_r  <= 1'b1;
      hdr_last_r <= 1'b0;
      bound_r    <= 1'b0;
      cur_slot_r <= '0;
      fc_r       <= '0;
      first_r    <= 1'b0;
      drn_k_r    <= '0;
      drn_len_r  <= '0;
      pend_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      exp_hdr_r  <= exp_hdr_nxt;
      hdr_last_r <= hdr_last_nxt;
      bound_r    <= bound_nxt;
      cur_slot_r <= cur_slot_nxt;
      fc_r       <= fc_nxt;
      first_r    <= first_nxt;
      drn_k_r    <= drn_k_nxt;
      drn_len_r  <= drn_len_nxt;
      pend_r     <= pend_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hdr_id_r   <= hdr_id_nxt;
    frm_bus_r  <= frm_bus_nxt;
    cur_base_r <= cur_base_nxt;
    new_r      <= new_nxt;
    len_r      <= len_nxt;
    ovf_r      <= ovf_nxt;
    drn_ovf_r  <= drn_ovf_nxt;
    if (issue) begin
      pend_last_r <= (drn_k_r + LEN_W'(1)) == drn_len_r;
    end
    if (load_out) begin
      out_d_r.out_bus      <= frm_bus_r;
      out_d_r.message_id   <= hdr_id_r;
      out_d_r.out_byte     <= mem_q_r;
      out_d_r.message_last <= pend_last_r;
      out_d_r.truncated    <= drn_ovf_r;
    end
  end

  // message store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= req.data_byte;
    end
    if (issue) begin
      mem_q_r <= store_mem[rd_addr];
    end
  end

  // slot metadata: read on the header, written back on every bound payload byte
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[cur_slot_r] <= {ovf_nxt, len_nxt};
    end
    if (lookup_en) begin
      meta_q_r <= meta_mem[lk_slot];
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.payload = out_d_r;

`ifndef SYNTHESIS
  // read data waiting on a stalled output must not be overwritten
  a_hold_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !out_free) |=> $stable(mem_q_r))
    else $error("drain read data changed while waiting for the output");

  // the drain never reads past the message length
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN) |-> (drn_k_r <= drn_len_r))
    else $error("drain index ran past message length");

  // no store write while a message is being streamed out
  a_no_wr_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN) |-> !st_we)
    else $error("message store written during drain");
`endif

endmodule

@@ verif/tb_frame_reassembler_top.sv @@
`timescale 1ns / 1ps

module tb_frame_reassembler_top;
  import fra_pkg::*;

  localparam int SLOTS        = 8;
  localparam int MSG_BYTES    = 64;
  localparam int FRAME_BYTES  = 32;
  // cycles without any request moving on either channel before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // settle time after the last message byte: output register plus drain overhead
  localparam int SETTLE_CYCLES = 12;
  // (bus, id) pairs that random traffic reuses so messages span frames and fill the pool
  localparam int NUM_KEYS     = 12;
  localparam int MAX_REPORTS  = 40;

  logic clk;
  logic rst_n;

  fra_stream_if #(.T(in_item_t))  in_if ();
  fra_stream_if #(.T(out_item_t)) out_if ();

  frame_reassembler_top #(
    .SLOTS(SLOTS),
    .MSG_BYTES(MSG_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if)
  );

  always #2 clk = ~clk;

  // Reassembly predictor: slot pool, message memory and the per-frame parse state.
  logic              slot_used  [SLOTS];
  logic [BUS_W-1:0]  slot_bus   [SLOTS];
  logic [ID_W-1:0]   slot_id    [SLOTS];
  int                slot_len   [SLOTS];
  logic              slot_trunc [SLOTS];
  logic [BYTE_W-1:0] msg_mem    [SLOTS][MSG_BYTES];
  logic              want_header;
  logic [BYTE_W-1:0] frame_header;
  int                frame_slot;
  logic              frame_bound;
  int                frame_payload;

  // message bytes still owed by the block, oldest first
  out_item_t pending_bytes[$];

  int src_idle_pct;
  int snk_idle_pct;
  int items_sent;
  int frames_sent;
  int bytes_checked;
  int truncated_msgs;
  int frames_dropped;
  int error_count;
  int idle_cycles;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (error_count < MAX_REPORTS)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    error_count++;
  endtask

  // Advance the predictor by one accepted request and queue the message bytes it releases.
  function automatic void reassemble_byte(in_item_t it);
    out_item_t ob;
    int        s;
    int        k;
    if (want_header) begin
      frame_header  = it.data_byte;
      frame_payload = 0;
      frame_bound   = 1'b0;
      // a header that also ends its frame carries nothing: ignore it
      if (it.frame_end)
        return;
      want_header = 1'b0;
      if (int'(it.bus) < BUSES) begin
        // join the message in progress for this bus and id
        for (s = 0; s < SLOTS && !frame_bound; s++) begin
          if (slot_used[s] && slot_bus[s] == it.bus &&
              slot_id[s] == it.data_byte[ID_W-1:0]) begin
            frame_slot  = s;
            frame_bound = 1'b1;
          end
        end
        // otherwise claim the lowest free slot
        for (s = 0; s < SLOTS && !frame_bound; s++) begin
          if (!slot_used[s]) begin
            slot_used[s]  = 1'b1;
            slot_bus[s]   = it.bus;
            slot_id[s]    = it.data_byte[ID_W-1:0];
            slot_len[s]   = 0;
            slot_trunc[s] = 1'b0;
            frame_slot    = s;
            frame_bound   = 1'b1;
          end
        end
      end
      if (!frame_bound)
        frames_dropped++;
      return;
    end

    // payload: the bus field no longer matters, the frame keeps its slot
    if (frame_bound) begin
      if (frame_payload >= FRAME_BYTES - 1) begin
        slot_trunc[frame_slot] = 1'b1;
      end else begin
        frame_payload++;
        if (slot_len[frame_slot] < MSG_BYTES) begin
          msg_mem[frame_slot][slot_len[frame_slot]] = it.data_byte;
          slot_len[frame_slot]++;
        end else begin
          slot_trunc[frame_slot] = 1'b1;
        end
      end
    end

    if (it.frame_end) begin
      want_header = 1'b1;
      // the end of a last frame releases the whole message and frees the slot
      if (frame_bound && frame_header[HDR_LAST_BIT]) begin
        for (k = 0; k < slot_len[frame_slot]; k++) begin
          ob.out_bus      = slot_bus[frame_slot];
          ob.message_id   = slot_id[frame_slot];
          ob.out_byte     = msg_mem[frame_slot][k];
          ob.message_last = (k == slot_len[frame_slot] - 1);
          ob.truncated    = slot_trunc[frame_slot];
          pending_bytes.push_back(ob);
        end
        if (slot_trunc[frame_slot])
          truncated_msgs++;
        slot_used[frame_slot] = 1'b0;
      end
      frame_bound = 1'b0;
    end
  endfunction

  // Present one frame byte, hold it until the block takes the request, then predict.
  task automatic send_frame_byte(input logic [BUS_W-1:0] bus, input logic [BYTE_W-1:0] data,
                                 input logic eof);
    in_item_t it;
    it.bus       = bus;
    it.data_byte = data;
    it.frame_end = eof;
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    reassemble_byte(it);
    items_sent++;
  endtask

  // Send a header and payload_len random payload bytes; zero length gives a header-only frame.
  task automatic send_frame(input logic [BUS_W-1:0] bus, input logic [ID_W-1:0] id,
                            input logic last, input int payload_len, input bit wander_bus);
    int               i;
    logic [BUS_W-1:0] b;
    send_frame_byte(bus, {last, id}, payload_len == 0);
    for (i = 1; i <= payload_len; i++) begin
      b = wander_bus ? BUS_W'($urandom_range(3)) : bus;
      send_frame_byte(b, BYTE_W'($urandom_range(255)), i == payload_len);
    end
    frames_sent++;
  endtask

  // Drop valid and hold off until every owed message byte has come out.
  task automatic await_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic test_directed_extremes();
    // header-only frame on the top bus with the last bit and top id: must be ignored
    send_frame_byte(2'd3, 8'hFF, 1'b1);
    // single last frame, bus 0 id 0, payload at both byte extremes
    send_frame_byte(2'd0, 8'h80, 1'b0);
    send_frame_byte(2'd0, 8'h00, 1'b0);
    send_frame_byte(2'd0, 8'hFF, 1'b1);
    // two-frame message on bus 3 id 127
    send_frame(2'd3, 7'h7F, 1'b0, 2, 1'b0);
    send_frame(2'd3, 7'h7F, 1'b1, 1, 1'b0);
    // bus field changes mid-frame: the bytes still belong to bus 1
    send_frame_byte(2'd1, {1'b1, 7'd5}, 1'b0);
    send_frame_byte(2'd2, 8'hA5, 1'b0);
    send_frame_byte(2'd3, 8'h5A, 1'b1);
    // interleave two messages on one bus
    send_frame(2'd2, 7'h55, 1'b0, 1, 1'b0);
    send_frame(2'd2, 7'h2A, 1'b1, 1, 1'b0);
    send_frame(2'd2, 7'h55, 1'b1, 1, 1'b0);
  endtask

  task automatic test_pool_full();
    int k;
    // occupy every slot with an open message
    for (k = 0; k < SLOTS; k++)
      send_frame(BUS_W'(k % 4), ID_W'(8'h10 + k), 1'b0, 1, 1'b0);
    // no slot left: this last frame is dropped and emits nothing
    send_frame(2'd2, 7'h7E, 1'b1, 3, 1'b0);
    for (k = 0; k < SLOTS; k++)
      send_frame(BUS_W'(k % 4), ID_W'(8'h10 + k), 1'b1, 1, 1'b0);
  endtask

  task automatic test_frame_overflow();
    // payload past the frame size is cut and flags the message
    send_frame(BUS_W'($urandom_range(3)), ID_W'($urandom_range(127)), 1'b1,
               FRAME_BYTES + 8, 1'b0);
  endtask

  task automatic test_message_overflow();
    logic [BUS_W-1:0] bus;
    logic [ID_W-1:0]  id;
    bus = BUS_W'($urandom_range(3));
    id  = ID_W'($urandom_range(127));
    // two full-size frames and a three-byte one overrun the message store by one byte
    send_frame(bus, id, 1'b0, FRAME_BYTES - 1, 1'b0);
    send_frame(bus, id, 1'b0, FRAME_BYTES - 1, 1'b0);
    send_frame(bus, id, 1'b1, 3, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int roll;
    int key;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        // stray header-only frame
        send_frame_byte(BUS_W'($urandom_range(3)), BYTE_W'($urandom_range(255)), 1'b1);
      end else if (roll < 12) begin
        // one-off message on a random key with a wandering bus field
        send_frame(BUS_W'($urandom_range(3)), ID_W'($urandom_range(127)), 1'b1,
                   $urandom_range(1, 4), 1'b1);
      end else begin
        key = $urandom_range(NUM_KEYS - 1);
        len = ($urandom_range(9) == 0) ? $urandom_range(20, FRAME_BYTES + 4)
                                       : $urandom_range(1, 6);
        send_frame(BUS_W'(key % 4),
                   (key == 0) ? 7'h00 : (key == NUM_KEYS - 1) ? 7'h7F : ID_W'(key * 23),
                   $urandom_range(99) < 40, len, $urandom_range(19) == 0);
      end
    end
  endtask

  // Result side: check each accepted message byte against the oldest owed one, then
  // pick the next ready level.
  initial begin
    out_item_t next_byte;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("message byte with nothing owed", out_if.payload.out_byte, 0);
        end else begin
          next_byte = pending_bytes.pop_front();
          if (out_if.payload.out_bus !== next_byte.out_bus)
            report_mismatch("out_bus", out_if.payload.out_bus, next_byte.out_bus);
          if (out_if.payload.message_id !== next_byte.message_id)
            report_mismatch("message_id", out_if.payload.message_id, next_byte.message_id);
          if (out_if.payload.out_byte !== next_byte.out_byte)
            report_mismatch("out_byte", out_if.payload.out_byte, next_byte.out_byte);
          if (out_if.payload.message_last !== next_byte.message_last)
            report_mismatch("message_last", out_if.payload.message_last,
                            next_byte.message_last);
          if (out_if.payload.truncated !== next_byte.truncated)
            report_mismatch("truncated", out_if.payload.truncated, next_byte.truncated);
        end
        bytes_checked++;
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: count cycles in which no request moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles with no request; %0d message bytes still owed",
                 idle_cycles, pending_bytes.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int s;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    for (s = 0; s < SLOTS; s++)
      slot_used[s] = 1'b0;
    want_header    = 1'b1;
    frame_header   = '0;
    frame_slot     = 0;
    frame_bound    = 1'b0;
    frame_payload  = 0;
    items_sent     = 0;
    frames_sent    = 0;
    bytes_checked  = 0;
    truncated_msgs = 0;
    frames_dropped = 0;
    error_count    = 0;
    idle_cycles    = 0;
    // sender idles lightly, receiver heavily
    src_idle_pct   = 19;
    snk_idle_pct   = 45;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_pool_full();
    await_drain();
    test_frame_overflow();
    test_message_overflow();
    test_random_traffic(80);
    await_drain();

    // swap the idle mix: sender heavy, receiver light
    src_idle_pct = 45;
    snk_idle_pct = 19;
    test_random_traffic(80);

    // back to back on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(80);

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d frame bytes in %0d frames; checked %0d message bytes, %0d truncated",
             items_sent, frames_sent, bytes_checked, truncated_msgs);
    $display("messages, %0d frames lost to a full pool, under three idle mixes.",
             frames_dropped);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
